>>> design/rmvs_pkg.sv
// ----------------------------------------------------------------------------
// rmvs_pkg
// Types and constants shared by the running mean and variance statistics unit.
// ----------------------------------------------------------------------------
package rmvs_pkg;

  localparam int DEF_SAMPLE_WIDTH = 32;
  localparam int DEF_COUNT_WIDTH  = 32;

  localparam int MEAN_W  = 48;
  localparam int MAG_W   = 49;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int SQ_W    = 64;
  localparam int ROOT_W  = 32;
  localparam int SREM_W  = 36;
  localparam int ITER_W  = 7;

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] sample;
  } in_item_t;

  typedef struct packed {
    logic        [31:0] sample_count;
    logic signed [31:0] mean_value;
    logic        [63:0] variance_value;
    logic        [31:0] stddev_value;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic               overflow_flag;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MDIV,
    ST_DEV,
    ST_MUL,
    ST_FIN_MUL,
    ST_VSET,
    ST_VDIV,
    ST_SQRT,
    ST_DONE
  } state_t;

endpackage

>>> design/running_mean_variance_stats_unit.sv
// ----------------------------------------------------------------------------
// running_mean_variance_stats_unit
// Welford running count, mean, m2, min and max with variance and std deviation.
// ----------------------------------------------------------------------------
// One item is processed at a time, one bit per cycle through a shared
// restoring divider, a shift-add multiplier and a digit-by-digit root.
// An add to a non-empty set runs the mean divide, deviation, multiply,
// variance divide and root; a clear or the first add runs only the root, and
// a saturated add the variance divide and root. The next item is taken
// while the previous result still waits in the output register.
module running_mean_variance_stats_unit
  import rmvs_pkg::*;
#(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int DIV_STEPS  = SQ_W;
  localparam int MUL_STEPS  = MAG_W;
  localparam int SQRT_STEPS = ROOT_W;

  state_t state_r, state_nxt;

  logic        [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic signed [MEAN_W-1:0]      mean_r, mean_nxt;
  logic        [SQ_W-1:0]        sq_r, sq_nxt;
  logic signed [31:0]            min_r, min_nxt;
  logic signed [31:0]            max_r, max_nxt;
  logic                          sat_r, sat_nxt;

  logic signed [MEAN_W-1:0]      x32_r, x32_nxt;
  logic signed [31:0]            xs_r, xs_nxt;
  logic        [MAG_W-1:0]       dmag_r, dmag_nxt;
  logic                          dneg_r, dneg_nxt;
  logic        [COUNT_WIDTH-1:0] n_r, n_nxt;

  logic        [SQ_W-1:0]        quo_r, quo_nxt;
  logic        [COUNT_WIDTH:0]   rem_r, rem_nxt;
  logic        [COUNT_WIDTH-1:0] den_r, den_nxt;
  logic        [PROD_W-1:0]      prod_r, prod_nxt;
  logic        [SQ_W-1:0]        var_r, var_nxt;
  logic        [SQ_W-1:0]        rv_r, rv_nxt;
  logic        [ROOT_W-1:0]      root_r, root_nxt;
  logic        [SREM_W-1:0]      srem_r, srem_nxt;
  logic        [ITER_W-1:0]      iter_r, iter_nxt;

  logic                          out_valid_r, out_valid_nxt;
  out_item_t                     out_r, out_nxt;

  logic signed [31:0]            xs;
  logic signed [MEAN_W-1:0]      x32;
  logic signed [MEAN_W:0]        dlt;
  logic        [COUNT_WIDTH:0]   dtrial;
  logic                          dbit;
  logic        [MAG_W:0]         msum;
  logic        [SREM_W-1:0]      sshift;
  logic        [SREM_W-1:0]      strial;
  logic signed [MEAN_W:0]        dlt2;
  logic        [MAG_W-1:0]       d2mag;
  logic        [SQ_W:0]          sqsum;
  logic        [63:0]            cext;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign xs     = 32'(signed'(in_data.sample[SAMPLE_WIDTH-1:0]));
  assign x32    = MEAN_W'(xs) <<< 16;
  assign dlt    = (MEAN_W+1)'(x32) - (MEAN_W+1)'(mean_r);
  assign dtrial = {rem_r[COUNT_WIDTH-1:0], quo_r[SQ_W-1]};
  assign dbit   = (dtrial >= {1'b0, den_r});
  assign msum   = {1'b0, prod_r[PROD_W-1:MAG_W]} + (prod_r[0] ? {1'b0, dmag_r} : '0);
  assign sshift = {srem_r[SREM_W-3:0], rv_r[SQ_W-1:SQ_W-2]};
  assign strial = {{(SREM_W-ROOT_W-2){1'b0}}, root_r, 2'b01};
  assign dlt2   = (MEAN_W+1)'(x32_r) - (MEAN_W+1)'(mean_r);
  assign d2mag  = dlt2[MEAN_W] ? MAG_W'(-dlt2) : MAG_W'(dlt2);
  assign sqsum  = {1'b0, sq_r} + {1'b0, prod_r[SQ_W+31:32]};
  assign cext   = 64'(count_r);

  // mean after the divide, from the finished quotient
  function automatic logic signed [MEAN_W-1:0] mean_upd_of(input logic [SQ_W-1:0] q);
    mean_upd_of = dneg_r ? mean_r - MEAN_W'(q[MAG_W-1:0]) : mean_r + MEAN_W'(q[MAG_W-1:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      mean_r      <= '0;
      sq_r        <= '0;
      min_r       <= '0;
      max_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      iter_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      mean_r      <= mean_nxt;
      sq_r        <= sq_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
      iter_r      <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x32_r  <= x32_nxt;
    xs_r   <= xs_nxt;
    dmag_r <= dmag_nxt;
    dneg_r <= dneg_nxt;
    n_r    <= n_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    prod_r <= prod_nxt;
    var_r  <= var_nxt;
    rv_r   <= rv_nxt;
    root_r <= root_nxt;
    srem_r <= srem_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    mean_nxt      = mean_r;
    sq_nxt        = sq_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    sat_nxt       = sat_r;
    x32_nxt       = x32_r;
    xs_nxt        = xs_r;
    dmag_nxt      = dmag_r;
    dneg_nxt      = dneg_r;
    n_nxt         = n_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    prod_nxt      = prod_r;
    var_nxt       = var_r;
    rv_nxt        = rv_r;
    root_nxt      = root_r;
    srem_nxt      = srem_r;
    iter_nxt      = iter_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.req_type == REQ_CLEAR) begin
            count_nxt = '0;
            mean_nxt  = '0;
            sq_nxt    = '0;
            min_nxt   = '0;
            max_nxt   = '0;
            sat_nxt   = 1'b0;
            state_nxt = ST_VSET;
          end else if (count_r == '0) begin
            count_nxt = COUNT_WIDTH'(1);
            mean_nxt  = x32;
            sq_nxt    = '0;
            min_nxt   = xs;
            max_nxt   = xs;
            state_nxt = ST_VSET;
          end else if (&count_r) begin
            sat_nxt   = 1'b1;
            state_nxt = ST_VSET;
          end else begin
            x32_nxt   = x32;
            xs_nxt    = xs;
            dneg_nxt  = dlt[MEAN_W];
            dmag_nxt  = dlt[MEAN_W] ? MAG_W'(-dlt) : MAG_W'(dlt);
            n_nxt     = count_r + COUNT_WIDTH'(1);
            den_nxt   = count_r + COUNT_WIDTH'(1);
            quo_nxt   = SQ_W'(dlt[MEAN_W] ? MAG_W'(-dlt) : MAG_W'(dlt));
            rem_nxt   = '0;
            iter_nxt  = '0;
            state_nxt = ST_MDIV;
          end
        end
      end
      ST_MDIV, ST_VDIV: begin
        rem_nxt  = dbit ? dtrial - {1'b0, den_r} : dtrial;
        quo_nxt  = {quo_r[SQ_W-2:0], dbit};
        iter_nxt = iter_r + ITER_W'(1);
        if (iter_r == ITER_W'(DIV_STEPS - 1)) begin
          iter_nxt = '0;
          if (state_r == ST_MDIV) begin
            state_nxt = ST_DEV;
          end else begin
            var_nxt   = quo_nxt;
            rv_nxt    = quo_nxt;
            root_nxt  = '0;
            srem_nxt  = '0;
            state_nxt = ST_SQRT;
          end
        end
      end
      ST_DEV: begin
        prod_nxt  = {{MAG_W{1'b0}}, d2mag};
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt = {msum, prod_r[MAG_W-1:1]};
        iter_nxt = iter_r + ITER_W'(1);
        if (iter_r == ITER_W'(MUL_STEPS - 1)) begin
          iter_nxt  = '0;
          state_nxt = ST_FIN_MUL;
        end
      end
      ST_VSET: begin
        if (count_r >= COUNT_WIDTH'(2)) begin
          quo_nxt   = sq_r;
          rem_nxt   = '0;
          den_nxt   = count_r - COUNT_WIDTH'(1);
          iter_nxt  = '0;
          state_nxt = ST_VDIV;
        end else begin
          var_nxt   = '0;
          rv_nxt    = '0;
          root_nxt  = '0;
          srem_nxt  = '0;
          iter_nxt  = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        rv_nxt   = {rv_r[SQ_W-3:0], 2'b00};
        if (sshift >= strial) begin
          srem_nxt = sshift - strial;
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          srem_nxt = sshift;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        iter_nxt = iter_r + ITER_W'(1);
        if (iter_r == ITER_W'(SQRT_STEPS - 1)) begin
          iter_nxt  = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.sample_count   = (cext[63:32] != 32'd0) ? 32'hFFFF_FFFF : cext[31:0];
          out_nxt.mean_value     = mean_r[MEAN_W-1:16];
          out_nxt.variance_value = var_r;
          out_nxt.stddev_value   = root_r;
          out_nxt.min_value      = min_r;
          out_nxt.max_value      = max_r;
          out_nxt.overflow_flag  = sat_r;
          out_valid_nxt          = 1'b1;
          state_nxt              = ST_IDLE;
        end
      end
      ST_FIN_MUL: begin
        if ((prod_r[PROD_W-1:SQ_W+32] != '0) || sqsum[SQ_W]) begin
          sq_nxt  = '1;
          sat_nxt = 1'b1;
        end else begin
          sq_nxt  = sqsum[SQ_W-1:0];
        end
        count_nxt = n_r;
        if (xs_r < min_r) min_nxt = xs_r;
        if (xs_r > max_r) max_nxt = xs_r;
        state_nxt = ST_VSET;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (state_r == ST_MDIV && iter_r == ITER_W'(DIV_STEPS - 1)) begin
      mean_nxt = mean_upd_of(quo_nxt);
    end
  end

endmodule

>>> verif/tb_running_mean_variance_stats_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_running_mean_variance_stats_unit
// Random and directed test of the running mean and variance statistics unit.
// Each accepted item updates a local Welford model, and the predicted
// statistics are checked field by field against every result in order.
// ----------------------------------------------------------------------------
module tb_running_mean_variance_stats_unit;
  import rmvs_pkg::*;

  class stats_scoreboard;
    bit [31:0]   n_cnt;
    logic signed [63:0] mean_q32;
    bit [63:0]   m2_sum;
    logic signed [63:0] lo_v;
    logic signed [63:0] hi_v;
    bit          sat;
    out_item_t   pending[$];
    int          errors;
    int          n_checked;

    function new();
      errors = 0;
      n_checked = 0;
      wipe();
    endfunction

    function void wipe();
      n_cnt = 0;
      mean_q32 = 0;
      m2_sum = 0;
      lo_v = 0;
      hi_v = 0;
      sat = 0;
    endfunction

    function bit [63:0] mag(logic signed [63:0] v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function bit [63:0] root64(bit [63:0] v);
      bit [63:0] r;
      bit [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function void note_item(in_item_t it);
      logic signed [63:0] x;
      logic signed [63:0] x32;
      logic signed [63:0] d;
      logic signed [63:0] d2;
      bit [63:0] q;
      bit [63:0] nn;
      bit [127:0] prod;
      bit [63:0] inc;
      bit [64:0] tot;
      bit [63:0] var_v;
      logic signed [63:0] m16;
      out_item_t o;
      if (it.req_type == REQ_CLEAR) begin
        wipe();
      end else begin
        x = 64'(it.sample);
        x32 = x * 65536;
        if (n_cnt == 0) begin
          n_cnt = 1;
          mean_q32 = x32;
          m2_sum = 0;
          lo_v = x;
          hi_v = x;
        end else if (n_cnt == 32'hFFFF_FFFF) begin
          sat = 1;
        end else begin
          nn = 64'(n_cnt) + 1;
          d = x32 - mean_q32;
          q = mag(d) / nn;
          mean_q32 = d < 0 ? mean_q32 - $signed(q) : mean_q32 + $signed(q);
          d2 = x32 - mean_q32;
          prod = 128'(mag(d)) * 128'(mag(d2));
          inc = prod[95:32];
          tot = 65'(m2_sum) + 65'(inc);
          if (prod[127:96] != 0 || tot[64]) begin
            m2_sum = '1;
            sat = 1;
          end else begin
            m2_sum = tot[63:0];
          end
          n_cnt = nn[31:0];
          if (x < lo_v) lo_v = x;
          if (x > hi_v) hi_v = x;
        end
      end
      var_v = n_cnt >= 2 ? m2_sum / (64'(n_cnt) - 1) : 64'd0;
      if (mean_q32 >= 0) m16 = mean_q32 >>> 16;
      else m16 = -$signed((mag(mean_q32) + 64'hFFFF) >> 16);
      o.sample_count = n_cnt;
      o.mean_value = m16[31:0];
      o.variance_value = var_v;
      o.stddev_value = 32'(root64(var_v));
      o.min_value = lo_v[31:0];
      o.max_value = hi_v[31:0];
      o.overflow_flag = sat;
      pending.push_back(o);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_checked);
    endtask

    task check_result(out_item_t r);
      out_item_t e;
      if (pending.size() == 0) begin
        report("unexpected result", 64'(r.sample_count), 64'd0);
        return;
      end
      e = pending.pop_front();
      if (r.sample_count !== e.sample_count)
        report("count", 64'(r.sample_count), 64'(e.sample_count));
      if (r.mean_value !== e.mean_value)
        report("mean", 64'(r.mean_value), 64'(e.mean_value));
      if (r.variance_value !== e.variance_value)
        report("variance", r.variance_value, e.variance_value);
      if (r.stddev_value !== e.stddev_value)
        report("stddev", 64'(r.stddev_value), 64'(e.stddev_value));
      if (r.min_value !== e.min_value)
        report("min", 64'(r.min_value), 64'(e.min_value));
      if (r.max_value !== e.max_value)
        report("max", 64'(r.max_value), 64'(e.max_value));
      if (r.overflow_flag !== e.overflow_flag)
        report("overflow", 64'(r.overflow_flag), 64'(e.overflow_flag));
      n_checked++;
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  stats_scoreboard sb;
  bit no_idle;
  int n_sent;
  int n_sat;
  int stall_left;

  running_mean_variance_stats_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // sample on the edge, then bring in the next ready value
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
      if (out_data.overflow_flag) n_sat++;
    end
    if (!rst_n || no_idle) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task send_item(logic kind, logic [31:0] val);
    in_item_t it;
    int gap;
    it.req_type = kind;
    it.sample = val;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
    n_sent++;
  endtask

  function logic [31:0] rand_sample();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      2: return $urandom_range(0, 255);
      3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return 32'(int'($urandom_range(0, 200)) - 100) * 32'd6554;
    endcase
  endfunction

  initial begin
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    sb = new();
    no_idle = 0;
    n_sent = 0;
    n_sat = 0;
    stall_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty clear, extremes, m2 saturation, clear resets flag
    send_item(REQ_CLEAR, 32'h1234_5678);
    send_item(REQ_ADD, 32'h7FFF_FFFF);
    send_item(REQ_ADD, 32'h8000_0000);
    send_item(REQ_ADD, 32'h7FFF_FFFF);
    send_item(REQ_ADD, 32'h8000_0000);
    send_item(REQ_ADD, 32'h0000_0000);
    send_item(REQ_ADD, 32'hFFFF_FFFF);
    send_item(REQ_CLEAR, 32'hFFFF_FFFF);
    send_item(REQ_ADD, 32'hFFFF_FFFF);
    send_item(REQ_ADD, 32'h0000_0001);
    send_item(REQ_ADD, 32'hFFFF_0000);
    send_item(REQ_ADD, 32'h0001_0000);
    send_item(REQ_ADD, 32'h0000_8000);
    send_item(REQ_CLEAR, 32'h0);
    send_item(REQ_ADD, 32'hFFFE_0000);
    send_item(REQ_ADD, 32'hFFFE_0000);
    send_item(REQ_ADD, 32'hFFFD_8000);
    send_item(REQ_ADD, 32'h0003_0000);
    in_valid <= 1'b0;
    // hold off until the unit has drained
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    for (int i = 0; i < 730; i++) begin
      if (i > 640) no_idle = 1;
      if ($urandom_range(0, 40) == 0) send_item(REQ_CLEAR, $urandom);
      else send_item(REQ_ADD, rand_sample());
    end
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("sent %0d items, checked %0d results, %0d with overflow set",
             n_sent, sb.n_checked, n_sat);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
